>>> sv/dns_query_responder_macros.svh
// Assertion macros used by the responder's queue module.
`ifndef DNS_QUERY_RESPONDER_MACROS_SVH
`define DNS_QUERY_RESPONDER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DQR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define DQR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/dqr_pkg.sv
// Package with the queue word type and fixed frame offsets of the responder.
`timescale 1ns / 1ps
package dqr_pkg;

  localparam int DNS_AT   = 42;
  localparam int QNAME_AT = 54;

  localparam logic [15:0] QTYPE_A    = 16'd1;
  localparam logic [15:0] QTYPE_AAAA = 16'd28;

  localparam logic [3:0] WORD_META  = 4'd8;
  localparam logic [3:0] WORD_ADDR0 = 4'd9;
  localparam logic [3:0] WORD_ADDR1 = 4'd10;
  localparam logic [3:0] WORD_VALID = 4'd11;

  typedef struct packed {
    logic             is_cfg;
    logic             bank;
    logic             ok;
    logic             aaaa;
    logic [15:0]      qclass;
    logic [7:0]       nlen;
    logic [18:0]      psum;
    logic [7:0][63:0] key;
    logic [7:0]       idx;
    logic [3:0]       word;
    logic [63:0]      value;
  } q_ent_t;

endpackage

>>> sv/dns_query_responder.sv
// Top level of the DNS A/AAAA query responder.
//
//   channel  | ports                                      | timing
//   input    | start, busy, in_action .. in_entry_value   | taken when start && !busy
//   result   | out_valid, out_verdict .. out_last         | cannot be stalled
//
// Frame bytes and table writes are taken one per cycle until the queue holds two words.
// A frame's search compares one name word per table read.
// A matching frame then emits one byte a cycle, from the header memory and the answer record, packed into 64-bit words.
// Reset clears the queue, the state machines and all record valid bits at once.
// Results cannot be stalled; busy holds off input while both queue slots are taken.
`timescale 1ns / 1ps
module dns_query_responder import dqr_pkg::*; #(
  parameter int MAX_NAME = 64,
  parameter int ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [7:0]  in_pkt_byte,
  input  logic        in_pkt_last,
  input  logic [7:0]  in_entry_index,
  input  logic [3:0]  in_entry_word,
  input  logic [63:0] in_entry_value,
  output logic        out_valid,
  output logic        out_verdict,
  output logic [63:0] out_word,
  output logic [3:0]  out_bytes,
  output logic        out_last
);

  localparam int HBW = $clog2(MAX_NAME + 64);

  logic           acc, push, pop, q_full, q_empty, rd_bank;
  q_ent_t         push_ent, q_head;
  logic [HBW-1:0] rd_addr;
  logic [7:0]     rd_data;

  assign busy = q_full;
  assign acc = start && !q_full;

  dqr_front #(.MAX_NAME(MAX_NAME)) u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc),
    .action(in_action), .pkt_byte(in_pkt_byte), .pkt_last(in_pkt_last),
    .entry_index(in_entry_index), .entry_word(in_entry_word),
    .entry_value(in_entry_value),
    .push(push), .push_ent(push_ent),
    .rd_bank(rd_bank), .rd_addr(rd_addr), .rd_data(rd_data)
  );

  dqr_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_ent(push_ent),
    .pop(pop), .head(q_head), .full(q_full), .empty(q_empty)
  );

  dqr_back #(.MAX_NAME(MAX_NAME), .ENTRIES(ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n), .head(q_head), .empty(q_empty), .pop(pop),
    .rd_bank(rd_bank), .rd_addr(rd_addr), .rd_data(rd_data),
    .out_valid(out_valid), .out_verdict(out_verdict), .out_word(out_word),
    .out_bytes(out_bytes), .out_last(out_last)
  );

endmodule

>>> sv/dqr_front.sv
// Front part: takes frame bytes and table writes, buffers headers and classifies frames.
`timescale 1ns / 1ps
module dqr_front import dqr_pkg::*; #(
  parameter int MAX_NAME = 64,
  localparam int HEAD_BYTES = MAX_NAME + 64,
  localparam int HBW = $clog2(HEAD_BYTES)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  logic           action,
  input  logic [7:0]     pkt_byte,
  input  logic           pkt_last,
  input  logic [7:0]     entry_index,
  input  logic [3:0]     entry_word,
  input  logic [63:0]    entry_value,
  output logic           push,
  output q_ent_t         push_ent,
  input  logic           rd_bank,
  input  logic [HBW-1:0] rd_addr,
  output logic [7:0]     rd_data
);

  logic [7:0] head_mem [2][HEAD_BYTES];

  logic [15:0] len_r, len_nxt, len_inc;
  logic        bank_r, bank_nxt;
  logic [7:0]  b12_r, b12_nxt, b13_r, b13_nxt, b23_r, b23_nxt;
  logic [7:0]  b36_r, b36_nxt, b37_r, b37_nxt, b44_r, b44_nxt;
  logic [7:0]  prev_r;
  logic [18:0] psum_r, psum_nxt;
  logic        found_r, found_nxt;
  logic [7:0]  nlen_r, nlen_nxt;
  logic [2:0]  tcnt_r, tcnt_nxt;
  logic        hinz_r, hinz_nxt;
  logic [15:0] qtype_r, qtype_nxt, qclass_r, qclass_nxt;
  logic [7:0][63:0] key_r, key_nxt;
  logic        fb, ok;
  logic [7:0]  ni;

  assign fb = acc && !action;
  assign len_inc = (len_r == 16'hFFFF) ? len_r : len_r + 16'd1;
  assign ni = 8'(len_r - 16'(QNAME_AT));

  always_ff @(posedge clk) begin
    if (fb && len_r < 16'(HEAD_BYTES)) begin
      head_mem[bank_r][HBW'(len_r)] <= pkt_byte;
    end
    rd_data <= head_mem[rd_bank][rd_addr];
  end

  always_comb begin
    len_nxt = len_r;
    bank_nxt = bank_r;
    b12_nxt = b12_r; b13_nxt = b13_r; b23_nxt = b23_r;
    b36_nxt = b36_r; b37_nxt = b37_r; b44_nxt = b44_r;
    psum_nxt = psum_r;
    found_nxt = found_r;
    nlen_nxt = nlen_r;
    tcnt_nxt = tcnt_r;
    hinz_nxt = hinz_r;
    qtype_nxt = qtype_r;
    qclass_nxt = qclass_r;
    key_nxt = key_r;
    push = 1'b0;
    if (fb) begin
      if (len_r == 16'd0) begin
        psum_nxt = '0;
        found_nxt = 1'b0;
        tcnt_nxt = '0;
        hinz_nxt = 1'b0;
        qtype_nxt = '0;
        qclass_nxt = '0;
        key_nxt = '0;
      end
      if (len_r == 16'd12) b12_nxt = pkt_byte;
      if (len_r == 16'd13) b13_nxt = pkt_byte;
      if (len_r == 16'd23) b23_nxt = pkt_byte;
      if (len_r == 16'd36) b36_nxt = pkt_byte;
      if (len_r == 16'd37) b37_nxt = pkt_byte;
      if (len_r == 16'(DNS_AT + 2)) b44_nxt = pkt_byte;
      if (len_r == 16'd15 || len_r == 16'd19 || len_r == 16'd21 || len_r == 16'd23 ||
          len_r == 16'd27 || len_r == 16'd29 || len_r == 16'd31 || len_r == 16'd33) begin
        psum_nxt = psum_nxt + 19'({prev_r, pkt_byte});
      end
      if (found_nxt && tcnt_nxt != 3'd4) begin
        case (tcnt_nxt)
          3'd0: qtype_nxt[15:8] = pkt_byte;
          3'd1: qtype_nxt[7:0] = pkt_byte;
          3'd2: qclass_nxt[15:8] = pkt_byte;
          default: qclass_nxt[7:0] = pkt_byte;
        endcase
        tcnt_nxt = tcnt_nxt + 3'd1;
      end
      if (len_r >= 16'(QNAME_AT) && len_r < 16'(QNAME_AT + MAX_NAME) && !found_nxt) begin
        if (pkt_byte == 8'd0) begin
          found_nxt = 1'b1;
          nlen_nxt = ni;
        end else if (ni[7:6] == 2'b00) begin
          key_nxt[ni[5:3]][{~ni[2:0], 3'b000} +: 8] = pkt_byte;
        end else begin
          hinz_nxt = 1'b1;
        end
      end
      len_nxt = len_inc;
      if (pkt_last) begin
        len_nxt = '0;
        bank_nxt = ~bank_r;
        push = 1'b1;
      end
    end
    if (acc && action) push = 1'b1;
  end

  assign ok = len_inc >= 16'(QNAME_AT) && b12_nxt == 8'h08 && b13_nxt == 8'h00 &&
              b23_nxt == 8'd17 && b36_nxt == 8'd0 && b37_nxt == 8'd53 &&
              (b44_nxt & 8'hF8) == 8'd0 && found_nxt && tcnt_nxt == 3'd4 &&
              (qtype_nxt == QTYPE_A || qtype_nxt == QTYPE_AAAA) && !hinz_nxt;

  always_comb begin
    push_ent = '0;
    push_ent.is_cfg = action;
    push_ent.bank = bank_r;
    push_ent.ok = ok;
    push_ent.aaaa = (qtype_nxt == QTYPE_AAAA);
    push_ent.qclass = qclass_nxt;
    push_ent.nlen = nlen_nxt;
    push_ent.psum = psum_nxt;
    push_ent.key = key_nxt;
    push_ent.idx = entry_index;
    push_ent.word = entry_word;
    push_ent.value = entry_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      bank_r <= 1'b0;
      found_r <= 1'b0;
      tcnt_r <= '0;
      hinz_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      bank_r <= bank_nxt;
      found_r <= found_nxt;
      tcnt_r <= tcnt_nxt;
      hinz_r <= hinz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b12_r <= b12_nxt; b13_r <= b13_nxt; b23_r <= b23_nxt;
    b36_r <= b36_nxt; b37_r <= b37_nxt; b44_r <= b44_nxt;
    if (fb) prev_r <= pkt_byte;
    psum_r <= psum_nxt;
    nlen_r <= nlen_nxt;
    qtype_r <= qtype_nxt;
    qclass_r <= qclass_nxt;
    key_r <= key_nxt;
  end

endmodule

>>> sv/dqr_queue.sv
// Two-entry queue between the front and back parts.
`timescale 1ns / 1ps
`include "dns_query_responder_macros.svh"
module dqr_queue import dqr_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  q_ent_t push_ent,
  input  logic   pop,
  output q_ent_t head,
  output logic   full,
  output logic   empty
);

  q_ent_t     ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  `DQR_ASSERT_IMPL(a_push_room, push, !full, "Word pushed into a full queue.")
  `DQR_ASSERT_IMPL(a_pop_data, pop, !empty, "Pop from an empty queue.")
  `DQR_ASSERT_NEXT(a_push_lands, push && !pop, !empty, "Pushed word did not land.")

endmodule

>>> sv/dqr_back.sv
// Back part: applies table writes, searches the record table and emits results.
`timescale 1ns / 1ps
module dqr_back import dqr_pkg::*; #(
  parameter int MAX_NAME = 64,
  parameter int ENTRIES = 256,
  localparam int HBW = $clog2(MAX_NAME + 64),
  localparam int PW = $clog2(MAX_NAME + 64 + 29),
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  q_ent_t         head,
  input  logic           empty,
  output logic           pop,
  output logic           rd_bank,
  output logic [HBW-1:0] rd_addr,
  input  logic [7:0]     rd_data,
  output logic           out_valid,
  output logic           out_verdict,
  output logic [63:0]    out_word,
  output logic [3:0]     out_bytes,
  output logic           out_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOOK = 2'd1;
  localparam logic [1:0] S_CSUM = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;
  localparam int ENT8 = ENTRIES * 8;

  logic [63:0]  name_mem [ENTRIES * 8];
  logic [63:0]  meta_mem [ENTRIES];
  logic [63:0]  alo_mem [ENTRIES];
  logic [63:0]  ahi_mem [ENTRIES];
  logic [63:0]  name_q, meta_q, alo_q, ahi_q;
  logic [ENTRIES-1:0] valid_r;

  logic [1:0]    st_r, st_nxt;
  logic [EW+3:0] scan_r, scan_nxt;
  logic          rvld_r, rvld_nxt;
  logic [2:0]    rwd_r, rwd_nxt;
  logic [EW-1:0] rent_r, rent_nxt;
  logic          acc_r, acc_nxt;
  logic [31:0]   ttl_r, ttl_nxt;
  logic [127:0]  addr_r, addr_nxt;
  logic [PW-1:0] total_r, total_nxt, ans_r, ans_nxt;
  logic [15:0]   csum_r, csum_nxt;
  logic [PW-1:0] rp_r, rp_nxt, dp_r, dp_nxt;
  logic          dvld_r, dvld_nxt;
  logic [63:0]   wbuf_r, wbuf_nxt;
  logic          ov_nxt, overd_nxt, olast_nxt;
  logic [63:0]   oword_nxt;
  logic [3:0]    obytes_nxt;

  logic          cfg_go, idx_ok;
  logic [EW-1:0] widx;
  logic [63:0]   nmask;
  logic          eq, acc_cur, hit;
  logic [15:0]   qtype, iplen, udplen;
  logic [19:0]   s0;
  logic [16:0]   s1, s2;
  logic [PW-1:0] src, ap;
  logic [4:0]    a5;
  logic [3:0]    ab;
  logic [7:0]    fbyte, alen;
  logic [63:0]   wb;

  assign cfg_go = (st_r == S_IDLE) && !empty && head.is_cfg;
  assign idx_ok = {24'd0, head.idx} < 32'(ENTRIES);
  assign widx = EW'(head.idx);

  always_ff @(posedge clk) begin
    if (cfg_go && idx_ok && !head.word[3]) name_mem[{widx, head.word[2:0]}] <= head.value;
    name_q <= name_mem[scan_r[EW+2:0]];
  end

  always_ff @(posedge clk) begin
    if (cfg_go && idx_ok && head.word == WORD_META) meta_mem[widx] <= head.value;
    meta_q <= meta_mem[scan_r[EW+2:3]];
  end

  always_ff @(posedge clk) begin
    if (cfg_go && idx_ok && head.word == WORD_ADDR0) alo_mem[widx] <= head.value;
    alo_q <= alo_mem[scan_r[EW+2:3]];
  end

  always_ff @(posedge clk) begin
    if (cfg_go && idx_ok && head.word == WORD_ADDR1) ahi_mem[widx] <= head.value;
    ahi_q <= ahi_mem[scan_r[EW+2:3]];
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      nmask[56 - 8 * k +: 8] = ((int'(rwd_r) * 8 + k) < MAX_NAME) ? 8'hFF : 8'h00;
    end
  end

  assign qtype = head.aaaa ? QTYPE_AAAA : QTYPE_A;
  assign alen = head.aaaa ? 8'd16 : 8'd4;
  assign eq = ((name_q ^ head.key[rwd_r]) & nmask) == 64'd0;
  assign acc_cur = (rwd_r == 3'd0) ? eq : (acc_r && eq);
  assign hit = acc_cur && valid_r[rent_r] && meta_q[31:16] == qtype &&
               meta_q[15:0] == head.qclass;

  assign iplen = 16'(total_r) - 16'd14;
  assign udplen = 16'(total_r) - 16'd34;
  assign s0 = 20'(head.psum) + 20'(iplen);
  assign s1 = 17'(s0[15:0]) + 17'(s0[19:16]);
  assign s2 = 17'(s1[15:0]) + 17'(s1[16]);

  always_comb begin
    if (rp_r < 6) src = rp_r + PW'(6);
    else if (rp_r < 12) src = rp_r - PW'(6);
    else if (rp_r >= 26 && rp_r < 30) src = rp_r + PW'(4);
    else if (rp_r >= 30 && rp_r < 34) src = rp_r - PW'(4);
    else if (rp_r == 34 || rp_r == 35) src = rp_r + PW'(2);
    else if (rp_r == 36 || rp_r == 37) src = rp_r - PW'(2);
    else src = rp_r;
    if (rp_r >= ans_r) src = '0;
  end

  assign rd_bank = head.bank;
  assign rd_addr = HBW'(src);

  assign ap = dp_r - ans_r;
  assign a5 = ap[4:0];
  assign ab = 4'(a5 - 5'd12);

  always_comb begin
    fbyte = rd_data;
    if (dp_r < ans_r) begin
      case (dp_r)
        PW'(16): fbyte = iplen[15:8];
        PW'(17): fbyte = iplen[7:0];
        PW'(24): fbyte = csum_r[15:8];
        PW'(25): fbyte = csum_r[7:0];
        PW'(38): fbyte = udplen[15:8];
        PW'(39): fbyte = udplen[7:0];
        PW'(40), PW'(41): fbyte = 8'h00;
        PW'(DNS_AT + 2), PW'(DNS_AT + 3): fbyte = rd_data | 8'h80;
        PW'(DNS_AT + 6): fbyte = 8'h00;
        PW'(DNS_AT + 7): fbyte = 8'h01;
        default: fbyte = rd_data;
      endcase
    end else begin
      case (a5)
        5'd0: fbyte = 8'hC0;
        5'd1: fbyte = 8'h0C;
        5'd2: fbyte = qtype[15:8];
        5'd3: fbyte = qtype[7:0];
        5'd4: fbyte = 8'h00;
        5'd5: fbyte = 8'h01;
        5'd6: fbyte = ttl_r[31:24];
        5'd7: fbyte = ttl_r[23:16];
        5'd8: fbyte = ttl_r[15:8];
        5'd9: fbyte = ttl_r[7:0];
        5'd10: fbyte = 8'h00;
        5'd11: fbyte = alen;
        default: fbyte = addr_r[{~ab, 3'b000} +: 8];
      endcase
    end
  end

  always_comb begin
    wb = wbuf_r;
    wb[{~dp_r[2:0], 3'b000} +: 8] = fbyte;
  end

  always_comb begin
    st_nxt = st_r;
    scan_nxt = scan_r;
    rvld_nxt = 1'b0;
    rwd_nxt = rwd_r;
    rent_nxt = rent_r;
    acc_nxt = acc_r;
    ttl_nxt = ttl_r;
    addr_nxt = addr_r;
    total_nxt = total_r;
    ans_nxt = ans_r;
    csum_nxt = csum_r;
    rp_nxt = rp_r;
    dp_nxt = dp_r;
    dvld_nxt = 1'b0;
    wbuf_nxt = wbuf_r;
    pop = 1'b0;
    ov_nxt = 1'b0;
    overd_nxt = 1'b0;
    oword_nxt = '0;
    obytes_nxt = '0;
    olast_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (!empty) begin
          if (head.is_cfg) begin
            pop = 1'b1;
          end else if (!head.ok) begin
            pop = 1'b1;
            ov_nxt = 1'b1;
            olast_nxt = 1'b1;
          end else begin
            scan_nxt = '0;
            st_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (scan_r < (EW + 4)'(ENT8)) begin
          rvld_nxt = 1'b1;
          rwd_nxt = scan_r[2:0];
          rent_nxt = scan_r[EW+2:3];
          scan_nxt = scan_r + 1'b1;
        end
        if (rvld_r) begin
          acc_nxt = acc_cur;
          if (rwd_r == 3'd7) begin
            if (hit) begin
              rvld_nxt = 1'b0;
              ttl_nxt = meta_q[63:32];
              addr_nxt = {alo_q, ahi_q};
              ans_nxt = PW'(QNAME_AT + 5) + PW'(head.nlen);
              total_nxt = PW'(QNAME_AT + 17) + PW'(head.nlen) + PW'(alen);
              st_nxt = S_CSUM;
            end else if (rent_r == EW'(ENTRIES - 1)) begin
              rvld_nxt = 1'b0;
              pop = 1'b1;
              ov_nxt = 1'b1;
              olast_nxt = 1'b1;
              st_nxt = S_IDLE;
            end
          end
        end
      end
      S_CSUM: begin
        csum_nxt = ~s2[15:0];
        rp_nxt = '0;
        wbuf_nxt = '0;
        st_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (rp_r < total_r) begin
          dvld_nxt = 1'b1;
          dp_nxt = rp_r;
          rp_nxt = rp_r + 1'b1;
        end
        if (dvld_r) begin
          if (dp_r[2:0] == 3'd7 || dp_r == total_r - 1'b1) begin
            ov_nxt = 1'b1;
            overd_nxt = 1'b1;
            oword_nxt = wb;
            obytes_nxt = {1'b0, dp_r[2:0]} + 4'd1;
            wbuf_nxt = '0;
            if (dp_r == total_r - 1'b1) begin
              olast_nxt = 1'b1;
              pop = 1'b1;
              st_nxt = S_IDLE;
            end
          end else begin
            wbuf_nxt = wb;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      rvld_r <= 1'b0;
      dvld_r <= 1'b0;
      out_valid <= 1'b0;
      valid_r <= '0;
    end else begin
      st_r <= st_nxt;
      rvld_r <= rvld_nxt;
      dvld_r <= dvld_nxt;
      out_valid <= ov_nxt;
      if (cfg_go && idx_ok && head.word == WORD_VALID) valid_r[widx] <= head.value[0];
    end
  end

  always_ff @(posedge clk) begin
    scan_r <= scan_nxt;
    rwd_r <= rwd_nxt;
    rent_r <= rent_nxt;
    acc_r <= acc_nxt;
    ttl_r <= ttl_nxt;
    addr_r <= addr_nxt;
    total_r <= total_nxt;
    ans_r <= ans_nxt;
    csum_r <= csum_nxt;
    rp_r <= rp_nxt;
    dp_r <= dp_nxt;
    wbuf_r <= wbuf_nxt;
    out_verdict <= overd_nxt;
    out_word <= oword_nxt;
    out_bytes <= obytes_nxt;
    out_last <= olast_nxt;
  end

endmodule
